### src/dtf_pkg.sv
// ----------------------------------------------------------------------------
// dtf_pkg
// Types, character codes and the fraction weight table for the decimal text
// to fixed-point parser.
// ----------------------------------------------------------------------------
package dtf_pkg;

   localparam int CHAR_W      = 8;
   localparam int VALUE_W     = 32;
   localparam int FRAC_ACC_W  = 36;   // binary fraction, binary point at bit 32
   localparam int SCALE_W     = 33;
   localparam int DIGIT_W     = 4;
   localparam int DCNT_W      = 4;
   localparam int FRAC_POINT  = 32;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;

   // weight of the tenth digit is already zero, so the count stops there
   localparam logic [DCNT_W-1:0] DIGITS_MAX = 4'd10;

   typedef enum logic [1:0] {
      MODE_SKIP = 2'd0,
      MODE_INT  = 2'd1,
      MODE_FRAC = 2'd2
   } mode_type;

   typedef struct packed {
      mode_type                mode;
      logic                    negative;
      logic                    saturated;
      logic [DCNT_W-1:0]       frac_digits;
   } ctl_type;

   // floor(2^32 / 10^k): repeated floor division by ten collapses to this
   function automatic logic [SCALE_W-1:0] scale_of(input logic [DCNT_W-1:0] k);
      logic [SCALE_W-1:0] s;
      case (k)
         4'd0:    s = 33'h1_0000_0000;
         4'd1:    s = 33'd429496729;
         4'd2:    s = 33'd42949672;
         4'd3:    s = 33'd4294967;
         4'd4:    s = 33'd429496;
         4'd5:    s = 33'd42949;
         4'd6:    s = 33'd4294;
         4'd7:    s = 33'd429;
         4'd8:    s = 33'd42;
         4'd9:    s = 33'd4;
         default: s = '0;
      endcase
      return s;
   endfunction

endpackage

### src/dtf_req_if.sv
// ----------------------------------------------------------------------------
// dtf_req_if
// Request channel: one text character and the end-of-stream mark.
// ----------------------------------------------------------------------------
interface dtf_req_if import dtf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_byte;
   logic              flush;

   modport source (output valid, output char_byte, output flush, input ready);
   modport sink   (input valid, input char_byte, input flush, output ready);
endinterface

### src/dtf_rsp_if.sv
// ----------------------------------------------------------------------------
// dtf_rsp_if
// Result channel: one parsed fixed-point number and its overflow flag.
// ----------------------------------------------------------------------------
interface dtf_rsp_if import dtf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic                      overflow;

   modport source (output valid, output value, output overflow, input ready);
   modport sink   (input valid, input value, input overflow, output ready);
endinterface

### src/dtf_step.sv
// ----------------------------------------------------------------------------
// dtf_step
// Per-character parse logic: next parser state and whether a number ends.
// ----------------------------------------------------------------------------
module dtf_step
   import dtf_pkg::*;
#(
   parameter int INT_BITS = 15
) (
   input  ctl_type                 cur_ctl,
   input  logic [INT_BITS-1:0]     cur_int,
   input  logic [FRAC_ACC_W-1:0]   cur_frac,
   input  logic [CHAR_W-1:0]       char_byte,
   input  logic                    flush,
   output ctl_type                 nxt_ctl,
   output logic [INT_BITS-1:0]     nxt_int,
   output logic [FRAC_ACC_W-1:0]   nxt_frac,
   output logic                    emit,
   output logic                    emit_next
);

   localparam int NW = INT_BITS + 4;
   localparam logic [NW-1:0] INT_MAX = NW'((64'd1 << INT_BITS) - 64'd1);

   logic                  is_digit;
   logic [CHAR_W-1:0]     char_off;
   logic [DIGIT_W-1:0]    digit;
   logic [NW-1:0]         int_sum;
   logic [DCNT_W-1:0]     digits_inc;
   logic [FRAC_ACC_W-1:0] addend;

   assign is_digit   = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);
   assign char_off   = char_byte - CHAR_ZERO;
   assign digit      = char_off[DIGIT_W-1:0];
   assign int_sum    = NW'(cur_int) * NW'(10) + NW'(digit);
   assign digits_inc = (cur_ctl.frac_digits == DIGITS_MAX) ? DIGITS_MAX
                                                           : cur_ctl.frac_digits + 1'b1;
   assign addend     = FRAC_ACC_W'(scale_of(digits_inc)) * FRAC_ACC_W'(digit);

   always_comb begin
      nxt_ctl   = cur_ctl;
      nxt_int   = cur_int;
      nxt_frac  = cur_frac;
      emit      = 1'b0;
      emit_next = 1'b0;

      case (cur_ctl.mode)
         MODE_INT: begin
            if (is_digit) begin
               if (int_sum > INT_MAX) begin
                  nxt_int           = INT_MAX[INT_BITS-1:0];
                  nxt_ctl.saturated = 1'b1;
               end else begin
                  nxt_int = int_sum[INT_BITS-1:0];
               end
            end else if (char_byte == CHAR_DOT) begin
               nxt_ctl.mode        = MODE_FRAC;
               nxt_ctl.frac_digits = '0;
               nxt_frac            = '0;
            end else begin
               // terminator is swallowed
               emit         = 1'b1;
               nxt_ctl.mode = MODE_SKIP;
            end
         end
         MODE_FRAC: begin
            if (is_digit) begin
               nxt_ctl.frac_digits = digits_inc;
               nxt_frac            = cur_frac + addend;
            end else begin
               emit         = 1'b1;
               nxt_ctl.mode = MODE_SKIP;
            end
         end
         default: begin
            nxt_ctl.mode = MODE_SKIP;
         end
      endcase

      // terminator of a fraction gets a second look, as from skipping
      if ((cur_ctl.mode != MODE_INT) && !(cur_ctl.mode == MODE_FRAC && is_digit)) begin
         if (is_digit) begin
            nxt_ctl.mode        = MODE_INT;
            nxt_ctl.negative    = 1'b0;
            nxt_ctl.saturated   = 1'b0;
            nxt_ctl.frac_digits = '0;
            nxt_int             = INT_BITS'(digit);
            nxt_frac            = '0;
         end else if (char_byte == CHAR_MINUS) begin
            nxt_ctl.mode        = MODE_INT;
            nxt_ctl.negative    = 1'b1;
            nxt_ctl.saturated   = 1'b0;
            nxt_ctl.frac_digits = '0;
            nxt_int             = '0;
            nxt_frac            = '0;
         end else if (char_byte == CHAR_DOT) begin
            nxt_ctl.mode        = MODE_FRAC;
            nxt_ctl.negative    = 1'b0;
            nxt_ctl.saturated   = 1'b0;
            nxt_ctl.frac_digits = '0;
            nxt_int             = '0;
            nxt_frac            = '0;
         end
      end

      if (flush) begin
         if (!emit && (nxt_ctl.mode != MODE_SKIP)) begin
            emit      = 1'b1;
            emit_next = 1'b1;
         end
         nxt_ctl.mode = MODE_SKIP;
      end
   end

endmodule

### src/dtf_emit.sv
// ----------------------------------------------------------------------------
// dtf_emit
// Builds the signed fixed-point result: rounds the binary fraction, joins
// the integer part, clamps and applies the sign.
// ----------------------------------------------------------------------------
module dtf_emit
   import dtf_pkg::*;
#(
   parameter int INT_BITS  = 15,
   parameter int FRAC_BITS = 16
) (
   input  logic                      negative,
   input  logic                      saturated,
   input  logic [INT_BITS-1:0]       int_acc,
   input  logic [FRAC_ACC_W-1:0]     frac_acc,
   output logic signed [VALUE_W-1:0] value,
   output logic                      overflow
);

   localparam int SHIFT  = FRAC_POINT - FRAC_BITS;
   localparam int WIDE_W = INT_BITS + FRAC_BITS + 2;
   localparam int CALC_W = (WIDE_W > FRAC_ACC_W + 4) ? WIDE_W : FRAC_ACC_W + 4;
   localparam logic [CALC_W-1:0] HALF    = (CALC_W'(1) << SHIFT) >> 1;
   localparam logic [CALC_W-1:0] MAG_MAX = (CALC_W'(1) << (INT_BITS + FRAC_BITS))
                                           - CALC_W'(1);

   logic [CALC_W-1:0] frac_round;
   logic [CALC_W-1:0] mag_raw;
   logic [CALC_W-1:0] mag;
   logic [CALC_W-1:0] signed_mag;

   always_comb begin
      frac_round = (CALC_W'(frac_acc) + HALF) >> SHIFT;
      mag_raw    = (CALC_W'(int_acc) << FRAC_BITS) + frac_round;
      // a rounding carry may push past full scale
      mag        = (mag_raw > MAG_MAX) ? MAG_MAX : mag_raw;
      signed_mag = negative ? (CALC_W'(0) - mag) : mag;
   end

   assign value    = signed_mag[VALUE_W-1:0];
   assign overflow = saturated;

endmodule

### src/decimal_text_to_fixed_parser_core.sv
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_parser_core
// ASCII decimal text to signed fixed-point number parser.
// ----------------------------------------------------------------------------
// Takes one character per clock and returns each finished decimal number
// ("12", "-3.25", ".5", "7.") as a signed two's complement value with
// INT_BITS integer and FRAC_BITS fraction bits, rounded half away from
// zero, together with a flag that the integer part saturated at
// 2^INT_BITS-1. Characters other than digits, '-' and '.' are skipped
// between numbers; a set flush bit closes a number still open after its
// character. The block accepts a request every clock while the result side
// keeps up; a number is offered on the result channel from the result
// register, after the request that ends it is taken into the request
// register, and while a number waits on a stalled result side the parse
// state holds and only one further request is taken.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_parser_core
   import dtf_pkg::*;
#(
   parameter int INT_BITS  = 15,
   parameter int FRAC_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   dtf_req_if.sink   req_ch,
   dtf_rsp_if.source rsp_ch
);

   logic                      in_valid_ff;
   logic [CHAR_W-1:0]         in_char_ff;
   logic                      in_flush_ff;

   ctl_type                   ctl_ff;
   logic [INT_BITS-1:0]       int_ff;
   logic [FRAC_ACC_W-1:0]     frac_ff;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic signed [VALUE_W-1:0] value_ff;
   logic                      overflow_ff;

   ctl_type                   nxt_ctl;
   logic [INT_BITS-1:0]       nxt_int;
   logic [FRAC_ACC_W-1:0]     nxt_frac;
   logic                      emit;
   logic                      emit_next;

   logic                      em_negative;
   logic                      em_saturated;
   logic [INT_BITS-1:0]       em_int;
   logic [FRAC_ACC_W-1:0]     em_frac;
   logic signed [VALUE_W-1:0] em_value;
   logic                      em_overflow;

   logic                      advance;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   dtf_step #(
      .INT_BITS (INT_BITS)
   ) u_step (
      .cur_ctl   (ctl_ff),
      .cur_int   (int_ff),
      .cur_frac  (frac_ff),
      .char_byte (in_char_ff),
      .flush     (in_flush_ff),
      .nxt_ctl   (nxt_ctl),
      .nxt_int   (nxt_int),
      .nxt_frac  (nxt_frac),
      .emit      (emit),
      .emit_next (emit_next)
   );

   // a flush closes the number as updated by this character
   assign em_negative  = emit_next ? nxt_ctl.negative  : ctl_ff.negative;
   assign em_saturated = emit_next ? nxt_ctl.saturated : ctl_ff.saturated;
   assign em_int       = emit_next ? nxt_int           : int_ff;
   assign em_frac      = emit_next ? nxt_frac          : frac_ff;

   dtf_emit #(
      .INT_BITS  (INT_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_emit (
      .negative  (em_negative),
      .saturated (em_saturated),
      .int_acc   (em_int),
      .frac_acc  (em_frac),
      .value     (em_value),
      .overflow  (em_overflow)
   );

   always_comb begin
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ctl_ff.mode        <= MODE_SKIP;
         ctl_ff.negative    <= 1'b0;
         ctl_ff.saturated   <= 1'b0;
         ctl_ff.frac_digits <= '0;
         int_ff       <= '0;
         frac_ff      <= '0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            ctl_ff  <= nxt_ctl;
            int_ff  <= nxt_int;
            frac_ff <= nxt_frac;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_char_ff  <= req_ch.char_byte;
         in_flush_ff <= req_ch.flush;
      end
      if (advance && emit) begin
         value_ff    <= em_value;
         overflow_ff <= em_overflow;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.value    = value_ff;
   assign rsp_ch.overflow = overflow_ff;

endmodule
